[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Each macro checks on the rising edge of clock and is quiet while reset is high.

`define ASSERT_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("pqs assertion failed");

`define ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pqs assertion failed");

`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pqs assertion failed");

`endif

[rtl/pqs_pkg.sv]
`timescale 1ns / 1ps

package pqs_pkg;

   localparam int DIST_W = 20;
   localparam int ID_W   = 31;
   localparam int TVAL_W = 16;
   localparam int CSR_W  = 5;
   localparam int CSR_IDX_W = 1;

   localparam logic [DIST_W-1:0] SUM_MAX = {DIST_W{1'b1}};

   localparam logic [1:0] OP_TABLE_WRITE = 2'd0;
   localparam logic [1:0] OP_CODE        = 2'd1;
   localparam logic [1:0] OP_FINISH      = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_TOP_COUNT     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_SUBSPACES = 1'b1;

   localparam logic [CSR_W-1:0] TOP_COUNT_RESET     = 5'd10;
   localparam logic [CSR_W-1:0] NUM_SUBSPACES_RESET = 5'd8;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic [ID_W-1:0]   id;
   } entry_type;

   localparam int ENTRY_W = DIST_W + ID_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_CMP,
      ST_PUT,
      ST_RPT
   } state_type;

endpackage

[rtl/pqs_ram.sv]
`timescale 1ns / 1ps

module pqs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             write_en,
   input  logic [AW-1:0]    write_addr,
   input  logic [WIDTH-1:0] write_data,
   input  logic [AW-1:0]    read_addr,
   output logic [WIDTH-1:0] read_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem[write_addr] <= write_data;
      end
      read_data_ff <= mem[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

[rtl/pqs_unit.sv]
`timescale 1ns / 1ps

module pqs_unit (
   input  logic [pqs_pkg::DIST_W-1:0] sum_value,
   input  logic [pqs_pkg::TVAL_W-1:0] add_value,
   input  logic                       add_enable,
   input  pqs_pkg::entry_type         candidate,
   input  pqs_pkg::entry_type         held,
   output logic [pqs_pkg::DIST_W-1:0] sum_result,
   output logic                       ranks_before
);

   import pqs_pkg::*;

   logic [DIST_W:0] wide_sum;

   // The running sum saturates at the largest 20-bit value.
   always_comb begin
      wide_sum = {1'b0, sum_value} +
                 (add_enable ? (DIST_W + 1)'(add_value) : (DIST_W + 1)'(0));
      sum_result = wide_sum[DIST_W] ? SUM_MAX : wide_sum[DIST_W-1:0];
   end

   // On equal distance the smaller id ranks first.
   assign ranks_before = (candidate.distance < held.distance) ||
                         ((candidate.distance == held.distance) &&
                          (candidate.id < held.id));

endmodule

[rtl/pq_adc_topk_scan.sv]
`timescale 1ns / 1ps

// Product-quantization distance scan with a sorted list of the k nearest vectors.
// A table write leaves the block idle, so the next beat may follow at once; so does a
// code beat whose subspace is at or beyond M and a beat with the unused opcode. Any
// other code beat reads the distance table into the table RAM's read register and then
// does the saturating add in ST_ADD. The code that ends a vector adds an insertion walk
// through the list memory, one compare per cycle over its single read port. A finish
// beat reads the list out: its entries go out one per cycle on consecutive cycles, each
// through the list memory's read register and then the output registers, so the last is
// on the result ports in the same cycle in which busy is first low; they are ranked by
// distance and then by id. An empty list sends one beat with valid_res low in the
// cycle right after the accepting edge. The receiver cannot stall, so rsp_strobe must
// be sampled on every cycle. The distance table is not cleared by reset.

`include "assert_macros.svh"

module pq_adc_topk_scan #(
   parameter int MAX_SUBSPACES = 16,
   parameter int CENTROIDS     = 256,
   parameter int MAX_TOP       = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_opcode,
   input  logic [3:0]                    req_subspace,
   input  logic [7:0]                    req_code,
   input  logic [pqs_pkg::TVAL_W-1:0]    req_table_value,
   input  logic [pqs_pkg::ID_W-1:0]      req_vector_id,
   output logic                          rsp_strobe,
   output logic [pqs_pkg::ID_W-1:0]      rsp_result_id,
   output logic [pqs_pkg::DIST_W-1:0]    rsp_result_distance,
   output logic [3:0]                    rsp_rank,
   output logic                          rsp_valid_res,
   output logic                          rsp_last,
   input  logic                          csr_write_enable,
   input  logic [pqs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pqs_pkg::CSR_W-1:0]     csr_write_data
);

   import pqs_pkg::*;

   localparam int TROWS  = (MAX_SUBSPACES < 16) ? MAX_SUBSPACES : 16;
   localparam int TDEPTH = TROWS * CENTROIDS;
   localparam int TAW    = $clog2(TDEPTH);
   localparam int KW     = $clog2(MAX_TOP + 1);
   localparam int LW     = (MAX_TOP > 1) ? $clog2(MAX_TOP) : 1;
   localparam int MW     = $clog2(MAX_SUBSPACES + 1);

   state_type            state_ff, state_in;
   logic [CSR_W-1:0]     top_count_ff;
   logic [CSR_W-1:0]     num_subspaces_ff;
   logic [DIST_W-1:0]    running_sum_ff, running_sum_in;
   logic [KW-1:0]        fill_ff, fill_in;
   logic [KW-1:0]        fnew_ff, fnew_in;
   logic [KW-1:0]        pos_ff, pos_in;
   logic [KW-1:0]        idx_ff, idx_in;
   logic [KW-1:0]        n_ff, n_in;
   entry_type            cand_ff, cand_in;
   logic                 use_tab_ff, use_tab_in;
   logic                 last_vec_ff, last_vec_in;
   logic [ID_W-1:0]      vid_ff, vid_in;

   logic                 strobe_ff, strobe_in;
   logic [ID_W-1:0]      out_id_ff, out_id_in;
   logic [DIST_W-1:0]    out_dist_ff, out_dist_in;
   logic [3:0]           out_rank_ff, out_rank_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 out_last_ff, out_last_in;

   logic                 accept;
   logic [KW-1:0]        k;
   logic [MW-1:0]        m;
   logic [KW-1:0]        f;
   logic                 sub_ok;
   logic                 code_ok;
   logic                 sub_beyond;
   logic                 sub_is_last;
   logic [TAW-1:0]       tab_addr;
   logic                 tab_we;
   logic [TVAL_W-1:0]    tab_rdata;

   logic                 list_we;
   logic [LW-1:0]        list_waddr;
   entry_type            list_wdata;
   logic [LW-1:0]        list_raddr;
   logic [ENTRY_W-1:0]   list_rdata;
   entry_type            held;

   logic [DIST_W-1:0]    unit_sum;
   logic                 unit_before;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   always_comb begin
      if (top_count_ff == '0) begin
         k = KW'(1);
      end else if (7'(top_count_ff) > 7'(MAX_TOP)) begin
         k = KW'(MAX_TOP);
      end else begin
         k = KW'(top_count_ff);
      end
      if (num_subspaces_ff == '0) begin
         m = MW'(1);
      end else if (7'(num_subspaces_ff) > 7'(MAX_SUBSPACES)) begin
         m = MW'(MAX_SUBSPACES);
      end else begin
         m = MW'(num_subspaces_ff);
      end
      f = (fill_ff < k) ? fill_ff : k;
   end

   assign sub_ok      = 7'(req_subspace) < 7'(MAX_SUBSPACES);
   assign code_ok     = {1'b0, req_code} < 9'(CENTROIDS);
   assign sub_beyond  = 7'(req_subspace) >= 7'(m);
   assign sub_is_last = 7'(req_subspace) == (7'(m) - 7'd1);
   assign tab_addr    = TAW'(32'(req_subspace) * 32'(CENTROIDS) + 32'(req_code));
   assign held        = entry_type'(list_rdata);

   pqs_ram #(
      .WIDTH (TVAL_W),
      .DEPTH (TDEPTH)
   ) u_table (
      .clock      (clock),
      .write_en   (tab_we),
      .write_addr (tab_addr),
      .write_data (req_table_value),
      .read_addr  (tab_addr),
      .read_data  (tab_rdata)
   );

   pqs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_TOP)
   ) u_list (
      .clock      (clock),
      .write_en   (list_we),
      .write_addr (list_waddr),
      .write_data (list_wdata),
      .read_addr  (list_raddr),
      .read_data  (list_rdata)
   );

   pqs_unit u_unit (
      .sum_value    (running_sum_ff),
      .add_value    (tab_rdata),
      .add_enable   (use_tab_ff),
      .candidate    (cand_ff),
      .held         (held),
      .sum_result   (unit_sum),
      .ranks_before (unit_before)
   );

   always_comb begin
      state_in       = state_ff;
      running_sum_in = running_sum_ff;
      fill_in        = fill_ff;
      fnew_in        = fnew_ff;
      pos_in         = pos_ff;
      idx_in         = idx_ff;
      n_in           = n_ff;
      cand_in        = cand_ff;
      use_tab_in     = use_tab_ff;
      last_vec_in    = last_vec_ff;
      vid_in         = vid_ff;
      strobe_in      = 1'b0;
      out_id_in      = out_id_ff;
      out_dist_in    = out_dist_ff;
      out_rank_in    = out_rank_ff;
      out_valid_in   = out_valid_ff;
      out_last_in    = out_last_ff;
      tab_we         = 1'b0;
      list_we        = 1'b0;
      list_waddr     = LW'(pos_ff);
      list_wdata     = cand_ff;
      list_raddr     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  OP_TABLE_WRITE: begin
                     tab_we = sub_ok && code_ok;
                  end
                  OP_CODE: begin
                     if (!sub_beyond) begin
                        use_tab_in  = code_ok;
                        last_vec_in = sub_is_last;
                        vid_in      = req_vector_id;
                        state_in    = ST_ADD;
                     end
                  end
                  OP_FINISH: begin
                     running_sum_in = '0;
                     fill_in        = '0;
                     if (f == '0) begin
                        strobe_in    = 1'b1;
                        out_id_in    = '0;
                        out_dist_in  = '0;
                        out_rank_in  = '0;
                        out_valid_in = 1'b0;
                        out_last_in  = 1'b1;
                     end else begin
                        n_in       = f;
                        idx_in     = '0;
                        list_raddr = '0;
                        state_in   = ST_RPT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ADD: begin
            if (last_vec_ff) begin
               running_sum_in   = '0;
               cand_in.distance = unit_sum;
               cand_in.id       = vid_ff;
               fnew_in          = (f == k) ? k : (f + KW'(1));
               pos_in           = f;
               if (f == '0) begin
                  state_in = ST_PUT;
               end else begin
                  list_raddr = LW'(f - KW'(1));
                  state_in   = ST_CMP;
               end
            end else begin
               running_sum_in = unit_sum;
               state_in       = ST_IDLE;
            end
         end
         ST_CMP: begin
            if (unit_before) begin
               // The held entry moves one place down; past the k-th place it drops out.
               list_we    = (pos_ff != k);
               list_wdata = held;
               pos_in     = pos_ff - KW'(1);
               if (pos_ff == KW'(1)) begin
                  state_in = ST_PUT;
               end else begin
                  list_raddr = LW'(pos_ff - KW'(2));
               end
            end else if (pos_ff == k) begin
               state_in = ST_IDLE;
            end else begin
               list_we  = 1'b1;
               fill_in  = fnew_ff;
               state_in = ST_IDLE;
            end
         end
         ST_PUT: begin
            list_we  = 1'b1;
            fill_in  = fnew_ff;
            state_in = ST_IDLE;
         end
         ST_RPT: begin
            strobe_in    = 1'b1;
            out_id_in    = held.id;
            out_dist_in  = held.distance;
            out_rank_in  = 4'(idx_ff);
            out_valid_in = 1'b1;
            out_last_in  = (KW'(idx_ff + KW'(1)) == n_ff);
            if (KW'(idx_ff + KW'(1)) == n_ff) begin
               state_in = ST_IDLE;
            end else begin
               idx_in     = idx_ff + KW'(1);
               list_raddr = LW'(idx_ff + KW'(1));
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         running_sum_ff <= '0;
         fill_ff        <= '0;
         fnew_ff        <= '0;
         pos_ff         <= '0;
         idx_ff         <= '0;
         n_ff           <= '0;
         use_tab_ff     <= 1'b0;
         last_vec_ff    <= 1'b0;
         strobe_ff      <= 1'b0;
      end else begin
         state_ff       <= state_in;
         running_sum_ff <= running_sum_in;
         fill_ff        <= fill_in;
         fnew_ff        <= fnew_in;
         pos_ff         <= pos_in;
         idx_ff         <= idx_in;
         n_ff           <= n_in;
         use_tab_ff     <= use_tab_in;
         last_vec_ff    <= last_vec_in;
         strobe_ff      <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff      <= cand_in;
      vid_ff       <= vid_in;
      out_id_ff    <= out_id_in;
      out_dist_ff  <= out_dist_in;
      out_rank_ff  <= out_rank_in;
      out_valid_ff <= out_valid_in;
      out_last_ff  <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_count_ff     <= TOP_COUNT_RESET;
         num_subspaces_ff <= NUM_SUBSPACES_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_TOP_COUNT:     top_count_ff     <= csr_write_data;
            CSR_NUM_SUBSPACES: num_subspaces_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_result_id       = out_id_ff;
   assign rsp_result_distance = out_dist_ff;
   assign rsp_rank            = out_rank_ff;
   assign rsp_valid_res       = out_valid_ff;
   assign rsp_last            = out_last_ff;

   `ASSERT_NEXT(a_report_beat, state_ff == ST_RPT, rsp_strobe && rsp_valid_res)
   `ASSERT_IMPLY(a_walk_bounds, state_ff == ST_CMP, (pos_ff != '0) && (pos_ff <= k))
   `ASSERT_ALWAYS(a_fill_bound, fill_ff <= KW'(MAX_TOP))
   `ASSERT_IMPLY(a_empty_is_last, rsp_strobe && !rsp_valid_res, rsp_last && (rsp_rank == '0))

endmodule
